### hw/rtl/fbik_pkg.sv
// ----------------------------------------------------------------------------
// fbik_pkg
// Types, constants and small helpers for the five-bar leg IK block.
// ----------------------------------------------------------------------------
package fbik_pkg;

	localparam int NumRegs = 5;
	localparam int RootW = 36;
	localparam int CordW = 44;
	localparam int AngW = 20;

	typedef enum logic [2:0] {
		REG_CRANK_A = 3'd0,
		REG_ROD_A = 3'd1,
		REG_ROD_B = 3'd2,
		REG_CRANK_B = 3'd3,
		REG_PIVOT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
	} in_item_t;

	typedef struct packed {
		logic [8:0] left_front_deg;
		logic [8:0] left_rear_deg;
		logic [8:0] right_front_deg;
		logic [8:0] right_rear_deg;
		logic left_unreachable;
		logic right_unreachable;
	} out_item_t;

	typedef struct packed {
		logic [7:0] crank_a_length;
		logic [7:0] rod_a_length;
		logic [7:0] rod_b_length;
		logic [7:0] crank_b_length;
		logic [7:0] pivot_spacing;
	} geom_t;

	localparam logic signed [AngW-1:0] TwoPiQ16 = 20'sd411775;
	localparam logic signed [AngW-1:0] QuarterPiQ16 = 20'sd51472;

	// ceil(2^40 * 36000 / 41156608): floor(m * DegRecip >> DegShift) is exact for m < 2^20
	localparam logic [29:0] DegRecip = 30'd961751236;
	localparam int DegShift = 40;

	function automatic logic [16:0] atan_tab(input logic [3:0] i);
		logic [16:0] v;
		case (i)
			4'd0: v = 17'd51472;
			4'd1: v = 17'd30386;
			4'd2: v = 17'd16055;
			4'd3: v = 17'd8150;
			4'd4: v = 17'd4091;
			4'd5: v = 17'd2047;
			4'd6: v = 17'd1024;
			4'd7: v = 17'd512;
			4'd8: v = 17'd256;
			4'd9: v = 17'd128;
			4'd10: v = 17'd64;
			4'd11: v = 17'd32;
			4'd12: v = 17'd16;
			4'd13: v = 17'd8;
			4'd14: v = 17'd4;
			default: v = 17'd2;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/fbik_isqrt.sv
// ----------------------------------------------------------------------------
// fbik_isqrt
// Pipelined floor square root of a 72-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module fbik_isqrt (
	input logic clk,
	input logic [71:0] din,
	output logic [fbik_pkg::RootW-1:0] root
);
	localparam int Stages = fbik_pkg::RootW / 2;

	logic [71:0] rem_s [Stages+1];
	logic [fbik_pkg::RootW-1:0] r_s [Stages+1];

	assign rem_s[0] = din;
	assign r_s[0] = '0;

	// restoring digit recurrence, two bits a stage, registered each stage
	for (genvar g = 0; g < Stages; g++) begin : g_stage
		logic [71:0] rem_c;
		logic [fbik_pkg::RootW-1:0] r_c;
		always_comb begin
			logic [73:0] trial;
			logic [73:0] rw;
			rem_c = rem_s[g];
			r_c = r_s[g];
			for (int k = 0; k < 2; k++) begin
				rw = {38'd0, r_c};
				trial = ((rw << 2) | 74'd1) << (70 - 2 * (2 * g + k));
				if ({2'b00, rem_c} >= trial) begin
					rem_c = rem_c - trial[71:0];
					r_c = {r_c[fbik_pkg::RootW-2:0], 1'b1};
				end else begin
					r_c = {r_c[fbik_pkg::RootW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_c;
			r_s[g+1] <= r_c;
		end
	end

	assign root = r_s[Stages];
endmodule

### hw/rtl/fbik_cordic.sv
// ----------------------------------------------------------------------------
// fbik_cordic
// Pipelined atan(n/d) in 2^-16 rad: normalise, then sixteen vectoring stages.
// ----------------------------------------------------------------------------
module fbik_cordic (
	input logic clk,
	input logic signed [37:0] num,
	input logic signed [37:0] den,
	output logic signed [fbik_pkg::AngW-1:0] ang
);
	localparam int W = fbik_pkg::CordW;

	logic signed [W-1:0] x_s [17];
	logic signed [W-1:0] y_s [17];
	logic signed [fbik_pkg::AngW-1:0] z_s [17];
	logic signed [W-1:0] xn_s1, yn_s1;
	logic zero_s1;

	// fold to right half plane and left-justify so max magnitude >= 2^40
	always_ff @(posedge clk) begin
		logic signed [W-1:0] xx, yy;
		logic [W-1:0] mx, my, m;
		xx = den[37] ? -W'(den) : W'(den);
		yy = den[37] ? -W'(num) : W'(num);
		mx = xx[W-1] ? -xx : xx;
		my = yy[W-1] ? -yy : yy;
		m = (mx > my) ? mx : my;
		zero_s1 <= (m == '0);
		// take each shift that keeps the magnitude below 2^41
		for (int k = 5; k >= 0; k--) begin
			if (m != '0 && m < (W'(1) << (41 - (1 << k)))) begin
				m = m << (1 << k);
				xx = xx <<< (1 << k);
				yy = yy <<< (1 << k);
			end
		end
		xn_s1 <= xx;
		yn_s1 <= yy;
	end

	assign x_s[0] = xn_s1;
	assign y_s[0] = yn_s1;
	assign z_s[0] = '0;

	for (genvar i = 0; i < 16; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (!y_s[i][W-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + fbik_pkg::AngW'(fbik_pkg::atan_tab(4'(i)));
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - fbik_pkg::AngW'(fbik_pkg::atan_tab(4'(i)));
			end
		end
	end

	logic [15:0] zero_d;
	always_ff @(posedge clk) zero_d <= {zero_d[14:0], zero_s1};

	assign ang = zero_d[15] ? '0 : z_s[16];
endmodule

### hw/rtl/fbik_leg.sv
// ----------------------------------------------------------------------------
// fbik_leg
// One leg lane: link terms, roots, four half-angle CORDICs, root choice, deg.
// ----------------------------------------------------------------------------
module fbik_leg (
	input logic clk,
	input fbik_pkg::geom_t geom,
	input logic signed [15:0] x,
	input logic signed [15:0] y,
	output logic signed [10:0] alpha_deg,
	output logic signed [10:0] beta_deg,
	output logic unreach
);
	localparam int RootLat = fbik_pkg::RootW / 2;

	logic signed [16:0] l1_s1, l2_s1, l3_s1, l4_s1, xs_s1;
	logic signed [16:0] x_s1, y_s1;
	logic signed [35:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [71:0] sab_s3, sde_s3, cc_s3, ff_s3;
	logic signed [35:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3;
	logic [71:0] da_s4, db_s4;
	logic na_s4, nb_s4;
	logic signed [35:0] a_s4, b_s4, c_s4, d_s4, e_s4, f_s4;

	// stage 1: scale lengths
	always_ff @(posedge clk) begin
		l1_s1 <= 17'(geom.crank_a_length) <<< 6;
		l2_s1 <= 17'(geom.rod_a_length) <<< 6;
		l3_s1 <= 17'(geom.rod_b_length) <<< 6;
		l4_s1 <= 17'(geom.crank_b_length) <<< 6;
		xs_s1 <= 17'(x) - (17'(geom.pivot_spacing) <<< 6);
		x_s1 <= 17'(x);
		y_s1 <= 17'(y);
	end

	// stage 2: terms a..f
	always_ff @(posedge clk) begin
		a_s2 <= (36'(x_s1) * 36'(l1_s1)) <<< 1;
		b_s2 <= (36'(y_s1) * 36'(l1_s1)) <<< 1;
		c_s2 <= 36'(x_s1) * 36'(x_s1) + 36'(y_s1) * 36'(y_s1)
			+ 36'(l1_s1) * 36'(l1_s1) - 36'(l2_s1) * 36'(l2_s1);
		d_s2 <= (36'(l4_s1) * 36'(xs_s1)) <<< 1;
		e_s2 <= (36'(l4_s1) * 36'(y_s1)) <<< 1;
		f_s2 <= 36'(xs_s1) * 36'(xs_s1) + 36'(l4_s1) * 36'(l4_s1)
			+ 36'(y_s1) * 36'(y_s1) - 36'(l3_s1) * 36'(l3_s1);
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		sab_s3 <= 72'(a_s2) * 72'(a_s2) + 72'(b_s2) * 72'(b_s2);
		sde_s3 <= 72'(d_s2) * 72'(d_s2) + 72'(e_s2) * 72'(e_s2);
		cc_s3 <= 72'(c_s2) * 72'(c_s2);
		ff_s3 <= 72'(f_s2) * 72'(f_s2);
		a_s3 <= a_s2; b_s3 <= b_s2; c_s3 <= c_s2;
		d_s3 <= d_s2; e_s3 <= e_s2; f_s3 <= f_s2;
	end

	// stage 4: discriminants
	always_ff @(posedge clk) begin
		na_s4 <= sab_s3 < cc_s3;
		nb_s4 <= sde_s3 < ff_s3;
		da_s4 <= (sab_s3 < cc_s3) ? '0 : 72'(sab_s3 - cc_s3);
		db_s4 <= (sde_s3 < ff_s3) ? '0 : 72'(sde_s3 - ff_s3);
		a_s4 <= a_s3; b_s4 <= b_s3; c_s4 <= c_s3;
		d_s4 <= d_s3; e_s4 <= e_s3; f_s4 <= f_s3;
	end

	logic [fbik_pkg::RootW-1:0] sa, sb;
	fbik_isqrt u_sqa (.clk(clk), .din(da_s4), .root(sa));
	fbik_isqrt u_sqb (.clk(clk), .din(db_s4), .root(sb));

	// delay line alongside the root pipes
	logic signed [35:0] ad_q [RootLat], bd_q [RootLat], cd_q [RootLat];
	logic signed [35:0] dd_q [RootLat], ed_q [RootLat], fd_q [RootLat];
	logic [RootLat-1:0] un_q;
	always_ff @(posedge clk) begin
		ad_q[0] <= a_s4; bd_q[0] <= b_s4; cd_q[0] <= c_s4;
		dd_q[0] <= d_s4; ed_q[0] <= e_s4; fd_q[0] <= f_s4;
		un_q[0] <= na_s4 | nb_s4;
		for (int k = 1; k < RootLat; k++) begin
			ad_q[k] <= ad_q[k-1]; bd_q[k] <= bd_q[k-1]; cd_q[k] <= cd_q[k-1];
			dd_q[k] <= dd_q[k-1]; ed_q[k] <= ed_q[k-1]; fd_q[k] <= fd_q[k-1];
			un_q[k] <= un_q[k-1];
		end
	end

	logic signed [37:0] n1_s5, n2_s5, n3_s5, n4_s5, da_s5, db_s5;
	logic un_s5;
	always_ff @(posedge clk) begin
		n1_s5 <= 38'(bd_q[RootLat-1]) + 38'(signed'({1'b0, sa}));
		n2_s5 <= 38'(bd_q[RootLat-1]) - 38'(signed'({1'b0, sa}));
		n3_s5 <= 38'(ed_q[RootLat-1]) + 38'(signed'({1'b0, sb}));
		n4_s5 <= 38'(ed_q[RootLat-1]) - 38'(signed'({1'b0, sb}));
		da_s5 <= 38'(ad_q[RootLat-1]) + 38'(cd_q[RootLat-1]);
		db_s5 <= 38'(dd_q[RootLat-1]) + 38'(fd_q[RootLat-1]);
		un_s5 <= un_q[RootLat-1];
	end

	logic signed [fbik_pkg::AngW-1:0] h1, h2, h3, h4;
	fbik_cordic u_c1 (.clk(clk), .num(n1_s5), .den(da_s5), .ang(h1));
	fbik_cordic u_c2 (.clk(clk), .num(n2_s5), .den(da_s5), .ang(h2));
	fbik_cordic u_c3 (.clk(clk), .num(n3_s5), .den(db_s5), .ang(h3));
	fbik_cordic u_c4 (.clk(clk), .num(n4_s5), .den(db_s5), .ang(h4));

	logic [16:0] und_q;
	always_ff @(posedge clk) und_q <= {und_q[15:0], un_s5};

	// choose roots
	logic signed [fbik_pkg::AngW-1:0] al_s6, be_s6;
	logic un_s6;
	always_ff @(posedge clk) begin
		logic signed [fbik_pkg::AngW-1:0] a1, a2, b1;
		a1 = h1 <<< 1;
		a2 = h2 <<< 1;
		b1 = h3 <<< 1;
		if (a1 < 0) a1 = a1 + fbik_pkg::TwoPiQ16;
		if (a2 < 0) a2 = a2 + fbik_pkg::TwoPiQ16;
		al_s6 <= (a1 >= fbik_pkg::QuarterPiQ16) ? a1 : a2;
		be_s6 <= (b1 >= 0 && b1 <= fbik_pkg::QuarterPiQ16) ? b1 : (h4 <<< 1);
		un_s6 <= und_q[16];
	end

	// degrees: trunc(a*36000/41156608) as a reciprocal multiply on the magnitude
	function automatic logic signed [10:0] to_deg(input logic signed [fbik_pkg::AngW-1:0] a);
		logic [19:0] m;
		logic [51:0] p;
		logic [10:0] q;
		m = a[fbik_pkg::AngW-1] ? 20'(-a) : 20'(a);
		p = 52'(m) * 52'(fbik_pkg::DegRecip);
		q = 11'(p >> fbik_pkg::DegShift);
		return a[fbik_pkg::AngW-1] ? -signed'(q) : signed'(q);
	endfunction

	always_ff @(posedge clk) begin
		alpha_deg <= to_deg(al_s6);
		beta_deg <= to_deg(be_s6);
		unreach <= un_s6;
	end
endmodule

### hw/rtl/five_bar_leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// five_bar_leg_inverse_kinematics
// Left and right five-bar leg lanes with a merging stage to servo set-points.
//
//  channel | signals                      | handshake
//  input   | start, busy, in_item         | accepted when start && !busy
//  result  | done, out_item               | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_*  | valid && ready
//
// One item a cycle enters; between the accepting edge and done there are
// 4 term stages, 18 root stages, 1 numerator stage, 17 CORDIC stages, root
// choice, degrees and the merge register. busy never rises. Reset clears
// registers to their geometry defaults and empties the valid pipe; results
// cannot stall.
// ----------------------------------------------------------------------------
module five_bar_leg_inverse_kinematics (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input fbik_pkg::in_item_t in_item,
	output logic done,
	output fbik_pkg::out_item_t out_item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data
);
	localparam int Lat = 4 + fbik_pkg::RootW / 2 + 1 + 17 + 1 + 1 + 1;

	fbik_pkg::geom_t geom_q;
	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '{8'd60, 8'd100, 8'd100, 8'd60, 8'd40};
		end else if (cfg_valid) begin
			case (cfg_index)
				fbik_pkg::REG_CRANK_A: geom_q.crank_a_length <= cfg_data;
				fbik_pkg::REG_ROD_A: geom_q.rod_a_length <= cfg_data;
				fbik_pkg::REG_ROD_B: geom_q.rod_b_length <= cfg_data;
				fbik_pkg::REG_CRANK_B: geom_q.crank_b_length <= cfg_data;
				fbik_pkg::REG_PIVOT: geom_q.pivot_spacing <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [10:0] la, lb, ra, rb;
	logic lu, ru;
	fbik_leg u_left (.clk(clk), .geom(geom_q), .x(in_item.left_x), .y(in_item.left_y),
		.alpha_deg(la), .beta_deg(lb), .unreach(lu));
	fbik_leg u_right (.clk(clk), .geom(geom_q), .x(in_item.right_x), .y(in_item.right_y),
		.alpha_deg(ra), .beta_deg(rb), .unreach(ru));

	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], start};
	end

	function automatic logic [8:0] sat(input logic signed [11:0] v);
		if (v < 0) return 9'd0;
		if (v > 12'sd300) return 9'd300;
		return 9'(v);
	endfunction

	// merge lanes into servo set-points
	always_ff @(posedge clk) begin
		out_item.left_front_deg <= sat(12'sd90 + 12'(lb));
		out_item.left_rear_deg <= sat(12'sd90 + 12'(la));
		out_item.right_front_deg <= sat(12'sd270 - 12'(rb));
		out_item.right_rear_deg <= sat(12'sd270 - 12'(ra));
		out_item.left_unreachable <= lu;
		out_item.right_unreachable <= ru;
	end
	assign done = vld_q[Lat-1];

	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, Lat)) else $error("result without item");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_item.left_rear_deg <= 9'd300 && out_item.right_rear_deg <= 9'd300))
		else $error("angle out of range");
endmodule
